// File: rtl/rsk_pkg.sv
// Package for the record sort block: record layout, cell link types and control states.
// Used by rsk_cell and record_sort_by_key_top; depends on nothing else.
package rsk_pkg;

  localparam int unsigned RSK_DEPTH = 16;

  localparam int unsigned KEY_W = 20;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned CLS_W = 2;
  localparam int unsigned TAG_W = 8;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [AMT_W-1:0] amount;
    logic [CLS_W-1:0] cls;
    logic [TAG_W-1:0] tag;
  } rsk_rec_t;

  // Command broadcast to every cell in the chain.
  typedef struct packed {
    logic     ins;
    logic     drain;
    rsk_rec_t rec;
  } rsk_bcast_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic     valid;
    logic     ins;
    rsk_rec_t rec;
  } rsk_link_t;

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } rsk_state_t;

endpackage

// File: rtl/rsk_cell.sv
// One cell of the insertion chain: holds one record and its valid bit.
// Depends on rsk_pkg.
module rsk_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  rsk_pkg::rsk_bcast_t bcast,
  input  rsk_pkg::rsk_link_t  from_left,
  input  rsk_pkg::rsk_link_t  from_right,
  output rsk_pkg::rsk_link_t  link
);
  import rsk_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  rsk_rec_t rec_r;
  rsk_rec_t rec_nxt;
  logic     ins;

  // The new item goes in front of every stored record with a strictly larger key.
  assign ins = !valid_r || (rec_r.key > bcast.rec.key);

  always_comb begin
    valid_nxt = valid_r;
    rec_nxt   = rec_r;
    if (bcast.drain) begin
      valid_nxt = from_right.valid;
      rec_nxt   = from_right.rec;
    end else if (bcast.ins && ins) begin
      if (from_left.ins) begin
        valid_nxt = from_left.valid;
        rec_nxt   = from_left.rec;
      end else begin
        valid_nxt = 1'b1;
        rec_nxt   = bcast.rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign link.valid = valid_r;
  assign link.ins   = ins;
  assign link.rec   = rec_r;

endmodule

// File: rtl/record_sort_by_key_top.sv
// Top level of the stable ascending record sorter: a chain of rsk_cell plus fill/drain control.
// Depends on rsk_pkg and rsk_cell.
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------------------
//   in      | input     | in_valid, in_ready, in_price_key, in_amount, in_discount_class,
//           |           | in_item_tag, in_batch_end
//   out     | output    | out_valid, out_ready, out_sorted_key, out_sorted_amount,
//           |           | out_sorted_class, out_sorted_tag, out_run_last, out_overflowed
//
// An input item is inserted into the sorted chain in the cycle it is accepted, one item per cycle
// while in_ready is high; if the chain is full, the item is dropped and out_overflowed is set.
// The item marked batch_end switches the block to draining: the n stored records leave from the
// head cell, one per cycle while out_ready is high, and in_ready stays low until the last is taken.
// Reset clears all valid bits, the overflow flag and the state; record contents are not reset.
// Stalls on the output simply hold the chain; no item is lost.
module record_sort_by_key_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rsk_pkg::KEY_W-1:0] in_price_key,
  input  logic [rsk_pkg::AMT_W-1:0] in_amount,
  input  logic [rsk_pkg::CLS_W-1:0] in_discount_class,
  input  logic [rsk_pkg::TAG_W-1:0] in_item_tag,
  input  logic                      in_batch_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rsk_pkg::KEY_W-1:0] out_sorted_key,
  output logic [rsk_pkg::AMT_W-1:0] out_sorted_amount,
  output logic [rsk_pkg::CLS_W-1:0] out_sorted_class,
  output logic [rsk_pkg::TAG_W-1:0] out_sorted_tag,
  output logic                      out_run_last,
  output logic                      out_overflowed
);
  import rsk_pkg::*;

  rsk_state_t state_r;
  rsk_state_t state_nxt;
  logic       drop_r;
  logic       drop_nxt;

  rsk_bcast_t bcast;
  rsk_link_t  links [RSK_DEPTH];
  logic [RSK_DEPTH-1:0] cell_vld;

  logic in_acc;
  logic out_acc;
  logic full;

  genvar gi;
  generate
    for (gi = 0; gi < RSK_DEPTH; gi++) begin : g_cell
      rsk_link_t left_link;
      rsk_link_t right_link;
      if (gi == 0) begin : g_head
        assign left_link = '0;
      end else begin : g_mid_l
        assign left_link = links[gi-1];
      end
      if (gi == RSK_DEPTH - 1) begin : g_tail
        assign right_link = '0;
      end else begin : g_mid_r
        assign right_link = links[gi+1];
      end
      rsk_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .bcast     (bcast),
        .from_left (left_link),
        .from_right(right_link),
        .link      (links[gi])
      );
      assign cell_vld[gi] = links[gi].valid;
    end
  endgenerate

  assign full    = links[RSK_DEPTH-1].valid;
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign bcast.ins        = in_acc && !full;
  assign bcast.drain      = out_acc;
  assign bcast.rec.key    = in_price_key;
  assign bcast.rec.amount = in_amount;
  assign bcast.rec.cls    = in_discount_class;
  assign bcast.rec.tag    = in_item_tag;

  always_comb begin
    state_nxt = state_r;
    drop_nxt  = drop_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end
          if (in_batch_end) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        if (out_acc && out_run_last) begin
          state_nxt = ST_FILL;
          drop_nxt  = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drop_r  <= drop_nxt;
    end
  end

  assign out_sorted_key    = links[0].rec.key;
  assign out_sorted_amount = links[0].rec.amount;
  assign out_sorted_class  = links[0].rec.cls;
  assign out_sorted_tag    = links[0].rec.tag;
  assign out_run_last      = !links[1].valid;
  assign out_overflowed    = drop_r;

  // The occupied cells always form a contiguous run starting at the head.
  a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_vld & (cell_vld + RSK_DEPTH'(1))) == '0))
    else $error("occupied cells are not contiguous from the head");

  // The two front records are in ascending key order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    links[1].valid |-> (links[0].rec.key <= links[1].rec.key))
    else $error("head records out of key order");

  // A result is only offered from an occupied head cell.
  a_out_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> links[0].valid)
    else $error("result offered from an empty chain");

  // Taking the last result of a run empties the chain and reopens the input.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_run_last) |=> (in_ready && (cell_vld == '0) && !out_overflowed))
    else $error("chain not cleared after the last result of a run");

endmodule
